### rtl/stm_pkg.sv
// Shared types, widths and constants for the square tile dihedral matcher.
// Used by stm_tile_bank, square_tile_dihedral_matcher and the bench; depends on nothing.
`default_nettype none

package stm_pkg;

    // Field widths fixed by the item format
    localparam int SIDE_W    = 5;
    localparam int COORD_W   = 4;
    localparam int VAL_W     = 8;
    localparam int CODE_W    = 3;
    localparam int MASK_W    = 8;

    // Tile store defaults
    localparam int MAX_SIDE_DEF = 16;
    localparam int N_ROT        = 4;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SIDE = 1'b0;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd3;

    // Operation codes of an input item
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPARE = 1'b1;

    // Result classes, ranked from first to last
    typedef enum logic [CODE_W-1:0] {
        CODE_ROT90     = 3'd0,
        CODE_ROT180    = 3'd1,
        CODE_ROT270    = 3'd2,
        CODE_MIRROR    = 3'd3,
        CODE_MIRROR_RT = 3'd4,
        CODE_SAME      = 3'd5,
        CODE_NONE      = 3'd6
    } code_t;

    // Lowest-ranked class among the surviving transforms
    function automatic code_t classify(input logic [MASK_W-1:0] m);
        code_t c;
        priority if (m[1])       c = CODE_ROT90;
        else if (m[2])           c = CODE_ROT180;
        else if (m[3])           c = CODE_ROT270;
        else if (m[4])           c = CODE_MIRROR;
        else if (|m[7:5])        c = CODE_MIRROR_RT;
        else if (m[0])           c = CODE_SAME;
        else                     c = CODE_NONE;
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/stm_tile_bank.sv
// One copy of the before-tile store: one write port, two registered read ports.
// Depends on stm_pkg for the cell width.
`default_nettype none

module stm_tile_bank #(
    parameter int DEPTH = stm_pkg::MAX_SIDE_DEF * stm_pkg::MAX_SIDE_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [stm_pkg::VAL_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr_a,
    input  wire logic [AW-1:0]             rd_addr_b,
    output logic      [stm_pkg::VAL_W-1:0] rd_data_a,
    output logic      [stm_pkg::VAL_W-1:0] rd_data_b
);

    logic [stm_pkg::VAL_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports, data held while the next stage is stalled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

### rtl/square_tile_dihedral_matcher.sv
// Top level of the square tile dihedral matcher: config register, address stage,
// compare stage and result register. Depends on stm_pkg and stm_tile_bank.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+-------------------------------------
//   cell     | cell_valid / cell_stall        | op, row, col, cell_value, last
//   result   | result_valid / result_stall    | code, match_mask
//   config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata (side at 0x0)
//
// One item per cycle while cell_stall is low. An accepted item and its tile reads are
// registered in the compare stage; compare and classify follow into the result register.
// The eight tile reads come from four copies of the store with two read ports each.
// Reset sets side to 3 and every flag to one and clears the valid bits; the tile store
// needs no clearing.
// A stalled result holds; the cell channel stalls only when the compare stage is full
// and its result cannot move on.
`default_nettype none

module square_tile_dihedral_matcher #(
    parameter int MAX_SIDE = stm_pkg::MAX_SIDE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [stm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [stm_pkg::PDATA_W-1:0] pwdata,
    output logic      [stm_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    // Cell channel
    input  wire logic                        cell_valid,
    output logic                             cell_stall,
    input  wire logic                        op,
    input  wire logic [stm_pkg::COORD_W-1:0] row,
    input  wire logic [stm_pkg::COORD_W-1:0] col,
    input  wire logic [stm_pkg::VAL_W-1:0]   cell_value,
    input  wire logic                        last,
    // Result channel
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic      [stm_pkg::CODE_W-1:0]  code,
    output logic      [stm_pkg::MASK_W-1:0]  match_mask
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = stm_pkg::SIDE_W;
    localparam int NR    = stm_pkg::N_ROT;

    // Flat cell index of (x, y) in the store
    function automatic logic [AW-1:0] cell_addr(input logic [SW-1:0] x,
                                                input logic [SW-1:0] y);
        return AW'(32'(x) * MAX_SIDE + 32'(y));
    endfunction

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [SW-1:0] side_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= stm_pkg::SIDE_RESET;
        end
        else if (cfg_wr && (paddr[2] == stm_pkg::REG_SIDE))
        begin
            side_reg <= pwdata[SW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == stm_pkg::REG_SIDE)
        begin
            prdata = stm_pkg::PDATA_W'(side_reg);
        end
    end

    // ---------------------------------------------------------------
    // Address stage: effective side, range check, eight source cells
    // ---------------------------------------------------------------
    logic [SW-1:0] eff_side;
    logic [SW-1:0] nm1;
    logic [SW-1:0] rr, cc;
    logic          in_range;
    logic          cell_acc;
    logic [SW-1:0] src_x [NR];
    logic [SW-1:0] src_y [NR];
    logic [AW-1:0] addr_a [NR];
    logic [AW-1:0] addr_b [NR];

    always_comb
    begin
        if (side_reg == '0)
        begin
            eff_side = SW'(1);
        end
        else if (32'(side_reg) > MAX_SIDE)
        begin
            eff_side = SW'(MAX_SIDE);
        end
        else
        begin
            eff_side = side_reg;
        end
    end

    assign nm1      = eff_side - SW'(1);
    assign rr       = SW'(row);
    assign cc       = SW'(col);
    assign in_range = (rr < eff_side) && (cc < eff_side);

    // Source of after cell (r,c) under k clockwise quarter turns
    always_comb
    begin
        src_x[0] = rr;        src_y[0] = cc;
        src_x[1] = nm1 - cc;  src_y[1] = rr;
        src_x[2] = nm1 - rr;  src_y[2] = nm1 - cc;
        src_x[3] = cc;        src_y[3] = nm1 - rr;
        for (int k = 0; k < NR; k++)
        begin
            addr_a[k] = cell_addr(src_x[k], src_y[k]);
            addr_b[k] = cell_addr(src_x[k], nm1 - src_y[k]);
        end
    end

    // ---------------------------------------------------------------
    // Tile store: four copies, each serving one rotation and its mirror
    // ---------------------------------------------------------------
    logic                      tile_wr;
    logic [stm_pkg::VAL_W-1:0] rd_a [NR];
    logic [stm_pkg::VAL_W-1:0] rd_b [NR];

    assign tile_wr = cell_acc && (op == stm_pkg::OP_LOAD) && in_range;

    for (genvar g = 0; g < NR; g++)
    begin : g_bank
        stm_tile_bank #(
            .DEPTH (DEPTH),
            .AW    (AW)
        ) u_bank (
            .clk       (clk),
            .wr_en     (tile_wr),
            .wr_addr   (addr_a[0]),
            .wr_data   (cell_value),
            .rd_en     (cell_acc),
            .rd_addr_a (addr_a[g]),
            .rd_addr_b (addr_b[g]),
            .rd_data_a (rd_a[g]),
            .rd_data_b (rd_b[g])
        );
    end

    // ---------------------------------------------------------------
    // Compare stage registers
    // ---------------------------------------------------------------
    logic                      s1_valid_reg, s1_valid_next;
    logic                      s1_op_reg;
    logic                      s1_last_reg;
    logic                      s1_range_reg;
    logic [stm_pkg::VAL_W-1:0] s1_val_reg;
    logic                      s1_emit;
    logic                      s1_go;
    logic                      out_free;

    assign s1_emit    = (s1_op_reg == stm_pkg::OP_COMPARE) && s1_last_reg;
    assign out_free   = !result_valid || !result_stall;
    assign s1_go      = s1_valid_reg && (!s1_emit || out_free);
    assign cell_stall = s1_valid_reg && !s1_go;
    assign cell_acc   = cell_valid && !cell_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cell_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_acc)
        begin
            s1_op_reg    <= op;
            s1_last_reg  <= last;
            s1_range_reg <= in_range;
            s1_val_reg   <= cell_value;
        end
    end

    // ---------------------------------------------------------------
    // Compare against the eight transforms and update the flags
    // ---------------------------------------------------------------
    logic [stm_pkg::MASK_W-1:0] flags_reg, flags_next;
    logic [stm_pkg::MASK_W-1:0] fail;
    logic [stm_pkg::MASK_W-1:0] mask_now;

    always_comb
    begin
        for (int k = 0; k < NR; k++)
        begin
            fail[k]      = (rd_a[k] != s1_val_reg);
            fail[k + NR] = (rd_b[k] != s1_val_reg);
        end
    end

    always_comb
    begin
        mask_now = flags_reg;
        if ((s1_op_reg == stm_pkg::OP_COMPARE) && s1_range_reg)
        begin
            mask_now = flags_reg & ~fail;
        end
        flags_next = flags_reg;
        if (s1_go)
        begin
            flags_next = s1_emit ? '1 : mask_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '1;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic                       res_valid_reg;
    stm_pkg::code_t             res_code_reg;
    logic [stm_pkg::MASK_W-1:0] res_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit)
        begin
            res_code_reg <= stm_pkg::classify(mask_now);
            res_mask_reg <= mask_now;
        end
    end

    assign result_valid = res_valid_reg;
    assign code         = res_code_reg;
    assign match_mask   = res_mask_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`ifndef NO_ASSERTIONS
    // The class is none exactly when no transform survived
    a_code_vs_mask: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((code == stm_pkg::CODE_NONE) == (match_mask == '0)))
        else $error("result class disagrees with match mask");

    // Flags return to all ones once a result is issued
    a_flags_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_emit) |=> (flags_reg == '1))
        else $error("flags not rearmed after result");

    // Between results the flags only ever lose bits
    a_flags_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && !s1_emit) |=> ((flags_reg & ~$past(flags_reg)) == '0))
        else $error("a cleared match flag came back");

    // The cell channel stalls only behind a held compare stage
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cell_stall |-> (s1_valid_reg && s1_emit && result_valid && result_stall))
        else $error("cell channel stalled without cause");
`endif

endmodule

`default_nettype wire

### bench/stm_match_checker.sv
// Scoreboard for the square tile dihedral matcher: tracks the side register, predicts
// each result from the accepted cells and compares it with what the result channel delivers.
// Depends on stm_pkg for widths, opcodes and the result class enum.
`default_nettype none

module stm_match_checker #(
    parameter int MAX_SIDE = stm_pkg::MAX_SIDE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic                        pready,
    input  wire logic [stm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [stm_pkg::PDATA_W-1:0] pwdata,
    input  wire logic                        cell_valid,
    input  wire logic                        cell_stall,
    input  wire logic                        op,
    input  wire logic [stm_pkg::COORD_W-1:0] row,
    input  wire logic [stm_pkg::COORD_W-1:0] col,
    input  wire logic [stm_pkg::VAL_W-1:0]   cell_value,
    input  wire logic                        last,
    input  wire logic                        result_valid,
    input  wire logic                        result_stall,
    input  wire logic [stm_pkg::CODE_W-1:0]  code,
    input  wire logic [stm_pkg::MASK_W-1:0]  match_mask,
    output int                               mismatches,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        stm_pkg::code_t             kind;
        logic [stm_pkg::MASK_W-1:0] mask;
    } tile_verdict_t;

    tile_verdict_t              pending_verdicts [$];
    logic [stm_pkg::VAL_W-1:0]  tile_copy [MAX_SIDE*MAX_SIDE];
    logic [stm_pkg::MASK_W-1:0] live_flags;
    logic [stm_pkg::SIDE_W-1:0] side_copy;

    always @(posedge clk or negedge rst_n)
    begin
        int span;
        int k;
        int sx;
        int sy;
        tile_verdict_t want;
        if (!rst_n)
        begin
            live_flags = '1;
            side_copy  = stm_pkg::SIDE_RESET;
            pending_verdicts.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // result channel: oldest prediction first
            if (result_valid && !result_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: code %0d mask %h", $time, code,
                             match_mask);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (code !== want.kind)
                    begin
                        mismatches++;
                        $display("%0t: code expected %0d actual %0d", $time, want.kind, code);
                    end
                    if (match_mask !== want.mask)
                    begin
                        mismatches++;
                        $display("%0t: match_mask expected %h actual %h", $time, want.mask,
                                 match_mask);
                    end
                end
            end

            // accepted cell, judged with the side in force before this edge
            if (cell_valid && !cell_stall)
            begin
                span = (side_copy == 0) ? 1 :
                       (side_copy > MAX_SIDE) ? MAX_SIDE : int'(side_copy);
                if (op == stm_pkg::OP_LOAD)
                begin
                    if (row < span && col < span)
                        tile_copy[row*MAX_SIDE + col] = cell_value;
                end
                else
                begin
                    if (row < span && col < span)
                    begin
                        // where each transform takes this after cell from
                        for (k = 0; k < stm_pkg::N_ROT; k++)
                        begin
                            case (k)
                                0:
                                begin
                                    sx = row;
                                    sy = col;
                                end
                                1:
                                begin
                                    sx = span - 1 - col;
                                    sy = row;
                                end
                                2:
                                begin
                                    sx = span - 1 - row;
                                    sy = span - 1 - col;
                                end
                                default:
                                begin
                                    sx = col;
                                    sy = span - 1 - row;
                                end
                            endcase
                            if (tile_copy[sx*MAX_SIDE + sy] != cell_value)
                                live_flags[k] = 1'b0;
                            if (tile_copy[sx*MAX_SIDE + span - 1 - sy] != cell_value)
                                live_flags[k+stm_pkg::N_ROT] = 1'b0;
                        end
                    end
                    if (last)
                    begin
                        // first surviving class in rank order
                        casez (live_flags)
                            8'b??????1?: want.kind = stm_pkg::CODE_ROT90;
                            8'b?????10?: want.kind = stm_pkg::CODE_ROT180;
                            8'b????100?: want.kind = stm_pkg::CODE_ROT270;
                            8'b???1000?: want.kind = stm_pkg::CODE_MIRROR;
                            8'b1??0000?,
                            8'b?1?0000?,
                            8'b??10000?: want.kind = stm_pkg::CODE_MIRROR_RT;
                            8'b00000001: want.kind = stm_pkg::CODE_SAME;
                            default:     want.kind = stm_pkg::CODE_NONE;
                        endcase
                        want.mask = live_flags;
                        pending_verdicts.push_back(want);
                        live_flags = '1;
                    end
                end
            end

            // side register write
            if (psel && penable && pwrite && pready && paddr[2] == stm_pkg::REG_SIDE)
                side_copy = pwdata[stm_pkg::SIDE_W-1:0];

            outstanding = pending_verdicts.size();
        end
    end

endmodule

`default_nettype wire

### bench/square_tile_dihedral_matcher_test.sv
// Testbench top for square_tile_dihedral_matcher: clock, reset, side register writes, cell
// stimulus with random idling and result stall bursts; stm_match_checker does the predicting
// and comparing. Depends on stm_pkg, stm_match_checker and the block itself.
`default_nettype none

module square_tile_dihedral_matcher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILE_MAX     = stm_pkg::MAX_SIDE_DEF;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_ITEMS   = 250;
    localparam int PHASE_ITEMS  = 120;
    localparam int LONG_HOLD    = 300;
    localparam int N_PLAN       = 12;
    localparam int SIDE_PLAN [N_PLAN] = '{2, 1, 0, 3, 4, 31, 5, 6, 3, 2, 1, 4};
    localparam logic [stm_pkg::PADDR_W-1:0] SIDE_ADDR =
        stm_pkg::PADDR_W'(4 * stm_pkg::REG_SIDE);

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        psel         = 1'b0;
    logic                        penable      = 1'b0;
    logic                        pwrite       = 1'b0;
    logic [stm_pkg::PADDR_W-1:0] paddr        = '0;
    logic [stm_pkg::PDATA_W-1:0] pwdata       = '0;
    logic [stm_pkg::PDATA_W-1:0] prdata;
    logic                        pready;
    logic                        cell_valid   = 1'b0;
    logic                        cell_stall;
    logic                        op           = stm_pkg::OP_LOAD;
    logic [stm_pkg::COORD_W-1:0] row          = '0;
    logic [stm_pkg::COORD_W-1:0] col          = '0;
    logic [stm_pkg::VAL_W-1:0]   cell_value   = '0;
    logic                        last         = 1'b0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic [stm_pkg::CODE_W-1:0]  code;
    logic [stm_pkg::MASK_W-1:0]  match_mask;
    int                          mismatches;
    int                          outstanding;

    // stimulus-side view of what has been loaded, used to build matching after-tiles
    logic [stm_pkg::VAL_W-1:0]  loaded [TILE_MAX][TILE_MAX];
    logic [stm_pkg::SIDE_W-1:0] cur_side = stm_pkg::SIDE_RESET;
    int                         sent = 0;
    bit                         gaps_on = 1'b0;
    bit                         stalls_on = 1'b0;
    bit                         quiet = 1'b0;
    bit                         long_hold_req = 1'b0;
    bit                         long_hold_done = 1'b0;

    square_tile_dihedral_matcher u_top (.*);

    stm_match_checker u_check (.*);

    always #4 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("square_tile_dihedral_matcher_test: FAIL");
        $finish;
    end

    function automatic int tile_span(input logic [stm_pkg::SIDE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > TILE_MAX)
            return TILE_MAX;
        return int'(s);
    endfunction

    // before-tile position that transform t carries onto after cell (r,c)
    function automatic void trace_back(input int t, input int n, input int r, input int c,
                                       output int x, output int y);
        case (t % stm_pkg::N_ROT)
            0:
            begin
                x = r;
                y = c;
            end
            1:
            begin
                x = n - 1 - c;
                y = r;
            end
            2:
            begin
                x = n - 1 - r;
                y = n - 1 - c;
            end
            default:
            begin
                x = c;
                y = n - 1 - r;
            end
        endcase
        if (t >= stm_pkg::N_ROT)
            y = n - 1 - y;
    endfunction

    task automatic send_cell(input logic o, input int r, input int c,
                             input logic [stm_pkg::VAL_W-1:0] v, input logic l);
        int n;
        n = tile_span(cur_side);
        if (gaps_on && !quiet && $urandom_range(0, 5) == 0)
        begin
            cell_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        cell_valid <= 1'b1;
        op         <= o;
        row        <= stm_pkg::COORD_W'(r);
        col        <= stm_pkg::COORD_W'(c);
        cell_value <= v;
        last       <= l;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
        if (o == stm_pkg::OP_LOAD && r < n && c < n)
            loaded[r][c] = v;
        sent++;
    endtask

    // wait until every predicted result is out, then let the pipeline drain
    task automatic settle();
        cell_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_side(input logic [stm_pkg::SIDE_W-1:0] s);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIDE_ADDR;
        pwdata  <= {(stm_pkg::PDATA_W - stm_pkg::SIDE_W)'($urandom), s};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_side = s;
    endtask

    // one sequence: mostly load + full compare of a transformed tile, else broken or noise
    task automatic play_sequence();
        int n;
        int style;
        int t;
        int amax;
        int bad;
        int x;
        int y;
        int r;
        int c;
        int j;
        int cnt;
        int pick;
        int tmp;
        int order [$];
        logic [stm_pkg::VAL_W-1:0] v;
        n = tile_span(cur_side);
        style = $urandom_range(0, 19);
        if (style < 14)
        begin
            case ($urandom_range(0, 3))
                0:       amax = 0;
                1:       amax = 1;
                2:       amax = 3;
                default: amax = 255;
            endcase
            if ($urandom_range(0, 4) != 0)
            begin
                for (r = 0; r < n; r++)
                    for (c = 0; c < n; c++)
                        send_cell(stm_pkg::OP_LOAD, r, c,
                                  stm_pkg::VAL_W'($urandom_range(0, amax)),
                                  $urandom_range(0, 7) == 0);
            end
            order = {};
            for (j = 0; j < n*n; j++)
                order.push_back(j);
            for (j = n*n - 1; j > 0; j--)
            begin
                pick = $urandom_range(0, j);
                tmp = order[j];
                order[j] = order[pick];
                order[pick] = tmp;
            end
            // t of 8 means an unrelated after-tile
            t = $urandom_range(0, 8);
            bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n*n - 1) : -1;
            for (j = 0; j < n*n; j++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_cell(stm_pkg::OP_LOAD, $urandom_range(0, n - 1),
                              $urandom_range(0, n - 1), stm_pkg::VAL_W'($urandom), 1'b0);
                r = order[j] / n;
                c = order[j] % n;
                trace_back(t % 8, n, r, c, x, y);
                v = (t == 8) ? stm_pkg::VAL_W'($urandom) : loaded[x][y];
                if (j == bad)
                    v = v ^ stm_pkg::VAL_W'($urandom_range(1, 255));
                send_cell(stm_pkg::OP_COMPARE, r, c, v, j == n*n - 1);
            end
        end
        else if (style < 17)
        begin
            // partial compare, closed by a cell off the tile where there is room
            t = $urandom_range(0, 7);
            cnt = $urandom_range(0, n*n - 1);
            for (j = 0; j < cnt; j++)
            begin
                r = $urandom_range(0, n - 1);
                c = $urandom_range(0, n - 1);
                trace_back(t, n, r, c, x, y);
                v = ($urandom_range(0, 3) == 0) ? stm_pkg::VAL_W'($urandom) : loaded[x][y];
                send_cell(stm_pkg::OP_COMPARE, r, c, v, 1'b0);
            end
            if (n < TILE_MAX)
                send_cell(stm_pkg::OP_COMPARE, $urandom_range(n, TILE_MAX - 1),
                          $urandom_range(0, TILE_MAX - 1), stm_pkg::VAL_W'($urandom), 1'b1);
            else
                send_cell(stm_pkg::OP_COMPARE, $urandom_range(0, n - 1),
                          $urandom_range(0, n - 1), stm_pkg::VAL_W'($urandom), 1'b1);
        end
        else
        begin
            cnt = $urandom_range(1, 8);
            for (j = 0; j < cnt; j++)
                send_cell(1'($urandom_range(0, 1)), $urandom_range(0, TILE_MAX - 1),
                          $urandom_range(0, TILE_MAX - 1), stm_pkg::VAL_W'($urandom),
                          1'($urandom_range(0, 1)));
        end
    endtask

    // result side: random stall bursts, one long hold during the side-1 phase
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (stalls_on && !quiet && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int r;
        int c;
        int phase;
        int used;
        logic [stm_pkg::SIDE_W-1:0] s;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write the whole store once so no compare ever reads an unwritten cell
        set_side(5'd16);
        for (r = 0; r < TILE_MAX; r++)
            for (c = 0; c < TILE_MAX; c++)
                send_cell(stm_pkg::OP_LOAD, r, c, stm_pkg::VAL_W'($urandom), 1'b0);
        settle();

        // directed cases at the reset side
        set_side(stm_pkg::SIDE_RESET);
        send_cell(stm_pkg::OP_LOAD, 0, 0, 8'h00, 1'b1);          // last on a load is ignored
        send_cell(stm_pkg::OP_LOAD, 15, 15, 8'hFF, 1'b0);        // off the tile, dropped
        send_cell(stm_pkg::OP_COMPARE, 15, 15, 8'hFF, 1'b1);     // off the tile, still closes
        send_cell(stm_pkg::OP_COMPARE, 0, 0, 8'hFF, 1'b0);
        send_cell(stm_pkg::OP_LOAD, 1, 1, 8'h5A, 1'b0);          // load between compares
        send_cell(stm_pkg::OP_COMPARE, 2, 2, 8'h00, 1'b1);
        // uniform tile: every transform survives
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                send_cell(stm_pkg::OP_LOAD, r, c, 8'h81, 1'b0);
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                send_cell(stm_pkg::OP_COMPARE, r, c, 8'h81, r == 2 && c == 2);
        settle();

        // random phases, each at its own side setting
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS || !quiet)
        begin
            if (phase < N_PLAN)
                s = stm_pkg::SIDE_W'(SIDE_PLAN[phase]);
            else
                s = stm_pkg::SIDE_W'($urandom_range(1, 8));
            set_side(s);
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            quiet     = (sent >= RANDOM_ITEMS - CALM_ITEMS);
            if (s == 1)
                long_hold_req = 1'b1;
            used = sent;
            while (sent - used < PHASE_ITEMS)
                play_sequence();
            settle();
            phase++;
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("square_tile_dihedral_matcher_test: PASS");
        else
            $display("square_tile_dihedral_matcher_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
